### sv/gbsu_pkg.sv
`default_nettype none

package gbsu_pkg;

    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 16;
    localparam int GENO_W  = 4;
    localparam int INDEX_W = 16;
    localparam int KIND_W  = 2;

    localparam logic [BYTE_W-1:0] MAGIC_FIRST    = 8'd108;
    localparam logic [BYTE_W-1:0] MAGIC_SECOND   = 8'd27;
    localparam logic [BYTE_W-1:0] MODE_SNP_MAJOR = 8'd1;

    localparam logic [GENO_W-1:0] GENO_HOM_REF  = 4'd0;
    localparam logic [GENO_W-1:0] GENO_HET      = 4'd1;
    localparam logic [GENO_W-1:0] GENO_HOM_ALT  = 4'd2;
    localparam logic [GENO_W-1:0] GENO_MISSING  = 4'd9;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] SLOT_LAST = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_GENOTYPE  = 2'd0,
        KIND_BAD_MAGIC = 2'd1,
        KIND_BAD_MODE  = 2'd2
    } kind_t;

    // one queued item: a data byte or an error marker
    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
    } work_item_t;

    function automatic logic [GENO_W-1:0] code_to_genotype(input logic [1:0] code);
        logic [GENO_W-1:0] g;
        begin
            unique case (code)
                2'b00:   g = GENO_HOM_REF;
                2'b01:   g = GENO_MISSING;
                2'b10:   g = GENO_HET;
                default: g = GENO_HOM_ALT;
            endcase
            return g;
        end
    endfunction

endpackage

`default_nettype wire

### sv/genotype_bed_stream_unpacker.sv
`default_nettype none

// Decodes a SNP-major genotype file stream fed one byte per item. The three
// header bytes are checked (magic 108, 27, then mode 1); a failure gives one
// error item and every later byte is dropped until reset. Each data byte
// gives one to four genotype items, low code first, with sample_index,
// row_end at samples_per_row and last on the final item of the byte.
// Results leave one per cycle from a single output register while out_ready
// is high and items wait; a data byte gives four items when the row does not
// end in it. A two-item queue sits between the header checker and the
// expander, so bytes are taken while results wait.
// samples_per_row (reset 1, zero means the full counter range) should be
// written only while the block is idle.

module genotype_bed_stream_unpacker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gbsu_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [gbsu_pkg::BYTE_W-1:0]   stream_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gbsu_pkg::KIND_W-1:0]        kind,
    output logic [gbsu_pkg::GENO_W-1:0]        genotype,
    output logic [gbsu_pkg::INDEX_W-1:0]       sample_index,
    output logic                               row_end,
    output logic                               last
);

    logic [gbsu_pkg::CFG_W-1:0] samples_per_row_reg;

    logic                  push;
    gbsu_pkg::work_item_t  push_item;
    logic                  queue_full;
    logic                  q_pop;
    logic                  q_not_empty;
    gbsu_pkg::work_item_t  q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_per_row_reg <= gbsu_pkg::CFG_W'(1);
        end
        else if (cfg_valid)
        begin
            samples_per_row_reg <= cfg_data;
        end
    end

    gbsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .stream_byte(stream_byte),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    gbsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head)
    );

    gbsu_back #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples_per_row(samples_per_row_reg),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .genotype       (genotype),
        .sample_index   (sample_index),
        .row_end        (row_end),
        .last           (last)
    );

endmodule

`default_nettype wire

### sv/gbsu_front.sv
`default_nettype none

module gbsu_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [gbsu_pkg::BYTE_W-1:0] stream_byte,
    output logic                            push,
    output gbsu_pkg::work_item_t            push_item,
    input  wire logic                       queue_full
);

    typedef enum logic [1:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_MODE,
        PH_DATA
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   mismatch_reg, mismatch_next;
    logic   error_reg, error_next;
    logic   accept;

    // dropped bytes after an error need no queue room
    assign in_ready = error_reg || !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next     = phase_reg;
        mismatch_next  = mismatch_reg;
        error_next     = error_reg;
        push           = 1'b0;
        push_item.kind = gbsu_pkg::KIND_GENOTYPE;
        push_item.data = stream_byte;
        if (accept && !error_reg)
        begin
            unique case (phase_reg)
                PH_MAGIC0:
                begin
                    mismatch_next = (stream_byte != gbsu_pkg::MAGIC_FIRST);
                    phase_next    = PH_MAGIC1;
                end
                PH_MAGIC1:
                begin
                    if (stream_byte != gbsu_pkg::MAGIC_SECOND)
                    begin
                        mismatch_next = 1'b1;
                    end
                    phase_next = PH_MODE;
                end
                PH_MODE:
                begin
                    if (mismatch_reg)
                    begin
                        error_next     = 1'b1;
                        push           = 1'b1;
                        push_item.kind = gbsu_pkg::KIND_BAD_MAGIC;
                    end
                    else if (stream_byte != gbsu_pkg::MODE_SNP_MAJOR)
                    begin
                        error_next     = 1'b1;
                        push           = 1'b1;
                        push_item.kind = gbsu_pkg::KIND_BAD_MODE;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    push = 1'b1;
                end
                default:
                begin
                    phase_next = PH_MAGIC0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC0;
            mismatch_reg <= 1'b0;
            error_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            mismatch_reg <= mismatch_next;
            error_reg    <= error_next;
        end
    end

endmodule

`default_nettype wire

### sv/gbsu_queue.sv
`default_nettype none

module gbsu_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire gbsu_pkg::work_item_t push_item,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output gbsu_pkg::work_item_t      head_item
);

    gbsu_pkg::work_item_t entries [gbsu_pkg::QUEUE_DEPTH];

    logic [gbsu_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gbsu_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gbsu_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full      = (count_reg == (gbsu_pkg::QUEUE_AW+1)'(gbsu_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### sv/gbsu_back.sv
`default_nettype none

module gbsu_back #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [gbsu_pkg::CFG_W-1:0]   samples_per_row,
    input  wire logic                         q_not_empty,
    input  wire gbsu_pkg::work_item_t         q_head,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [gbsu_pkg::KIND_W-1:0]       kind,
    output logic [gbsu_pkg::GENO_W-1:0]       genotype,
    output logic [gbsu_pkg::INDEX_W-1:0]      sample_index,
    output logic                              row_end,
    output logic                              last
);

    gbsu_pkg::work_item_t     cur_reg, cur_next;
    logic                     cur_valid_reg, cur_valid_next;
    logic [1:0]               slot_reg, slot_next;
    logic [SAMPLE_WIDTH-1:0]  pos_reg, pos_next;

    logic                          out_valid_reg, out_valid_next;
    logic [gbsu_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [gbsu_pkg::GENO_W-1:0]   geno_reg, geno_next;
    logic [gbsu_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic                          row_end_reg, row_end_next;
    logic                          last_reg, last_next;

    logic [SAMPLE_WIDTH-1:0]  lim_raw;
    logic [SAMPLE_WIDTH:0]    lim;
    logic [SAMPLE_WIDTH:0]    pos_inc;
    logic [gbsu_pkg::INDEX_W-1:0] pos_index;
    logic [1:0]               code;
    logic                     is_end;
    logic                     advance;
    logic                     done;

    if (SAMPLE_WIDTH > gbsu_pkg::CFG_W)
    begin : g_lim_wide
        assign lim_raw = {{(SAMPLE_WIDTH-gbsu_pkg::CFG_W){1'b0}}, samples_per_row};
    end
    else
    begin : g_lim_narrow
        assign lim_raw = samples_per_row[SAMPLE_WIDTH-1:0];
    end

    if (SAMPLE_WIDTH >= gbsu_pkg::INDEX_W)
    begin : g_idx_wide
        assign pos_index = pos_reg[gbsu_pkg::INDEX_W-1:0];
    end
    else
    begin : g_idx_narrow
        assign pos_index = {{(gbsu_pkg::INDEX_W-SAMPLE_WIDTH){1'b0}}, pos_reg};
    end

    // a zero count stands for a full counter range
    assign lim     = (lim_raw == '0) ? {1'b1, {SAMPLE_WIDTH{1'b0}}} : {1'b0, lim_raw};
    assign pos_inc = {1'b0, pos_reg} + 1'b1;
    assign is_end  = (pos_inc >= lim);

    always_comb
    begin
        case (slot_reg)
            2'd0:    code = cur_reg.data[1:0];
            2'd1:    code = cur_reg.data[3:2];
            2'd2:    code = cur_reg.data[5:4];
            default: code = cur_reg.data[7:6];
        endcase
    end

    assign advance = cur_valid_reg && (!out_valid_reg || out_ready);
    assign done    = (cur_reg.kind != gbsu_pkg::KIND_GENOTYPE) || is_end
                     || (slot_reg == gbsu_pkg::SLOT_LAST);
    assign q_pop   = q_not_empty && (!cur_valid_reg || (advance && done));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        slot_next      = slot_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        geno_next      = geno_reg;
        index_next     = index_reg;
        row_end_next   = row_end_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            kind_next      = cur_reg.kind;
            last_next      = done;
            slot_next      = slot_reg + 1'b1;
            if (cur_reg.kind == gbsu_pkg::KIND_GENOTYPE)
            begin
                geno_next    = gbsu_pkg::code_to_genotype(code);
                index_next   = pos_index;
                row_end_next = is_end;
                pos_next     = is_end ? '0 : pos_inc[SAMPLE_WIDTH-1:0];
            end
            else
            begin
                geno_next    = '0;
                index_next   = '0;
                row_end_next = 1'b0;
            end
            if (done)
            begin
                cur_valid_next = 1'b0;
            end
        end

        if (q_pop)
        begin
            cur_next       = q_head;
            cur_valid_next = 1'b1;
            slot_next      = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        kind_reg    <= kind_next;
        geno_reg    <= geno_next;
        index_reg   <= index_next;
        row_end_reg <= row_end_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            slot_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            slot_reg      <= slot_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign genotype     = geno_reg;
    assign sample_index = index_reg;
    assign row_end      = row_end_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire
